@@ sv/npc_pkg.sv @@
`default_nettype none

package npc_pkg;

  localparam int PALETTE_SIZE = 16;

  localparam int COMP_W = 8;
  localparam int SLOT_W = 4;
  localparam int CIDX_W = 4;
  localparam int SQ_W   = 2 * COMP_W;
  localparam int DIST_W = 18;
  localparam int IDX_W  = $clog2(PALETTE_SIZE);
  localparam int CMP_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } npc_item_t;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

@@ sv/nearest_palette_colour.sv @@
`default_nettype none

// Nearest palette colour search. Each request either loads one palette entry
// (red, green, blue at entry_index) or classifies a pixel, returning the index
// of the palette entry with the smallest squared RGB distance and that
// distance; the lowest index wins on a tie. The palette is cleared to black at
// reset. A chain of PALETTE_SIZE cells, each holding one entry, carries every
// request along, so one request is taken per clock unless the chain stops;
// a classification passes both registers of every cell and then the output
// register. A load takes effect for every request that follows it. Load
// requests give no result. The chain stops only when a result sits in the
// output register unread and another result has reached the end of the chain.

module nearest_palette_colour import npc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [SLOT_W-1:0] in_entry_index,
  input  logic [COMP_W-1:0] in_red,
  input  logic [COMP_W-1:0] in_green,
  input  logic [COMP_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CIDX_W-1:0] out_colour_index,
  output logic [DIST_W-1:0] out_distance_squared
);

  npc_item_t         chain [PALETTE_SIZE+1];
  npc_item_t         last;
  logic              advance;
  logic              last_result;
  logic              out_free;
  logic              out_valid_r;
  logic [CIDX_W-1:0] out_colour_index_r;
  logic [DIST_W-1:0] out_distance_r;
  logic [CMP_W-1:0]  idx_ext;

  assign last        = chain[PALETTE_SIZE];
  assign last_result = last.valid && (last.op == OP_CLASSIFY);
  assign out_free    = !out_valid_r || !out_stall;
  assign advance     = out_free || !last_result;
  assign in_stall    = !advance;

  always_comb begin
    chain[0].valid     = in_valid;
    chain[0].op        = in_operation;
    chain[0].slot      = in_entry_index;
    chain[0].red       = in_red;
    chain[0].green     = in_green;
    chain[0].blue      = in_blue;
    chain[0].best_dist = '1;
    chain[0].best_idx  = '0;
  end

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    npc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (IDX_W'(i)),
      .item_in  (chain[i]),
      .item_out (chain[i+1])
    );
  end

  assign idx_ext = CMP_W'(last.best_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= last_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && last_result) begin
      out_colour_index_r <= idx_ext[CIDX_W-1:0];
      out_distance_r     <= last.best_dist;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_colour_index     = out_colour_index_r;
  assign out_distance_squared = out_distance_r;

endmodule

`default_nettype wire

@@ sv/npc_cell.sv @@
`default_nettype none

module npc_cell import npc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [IDX_W-1:0] cell_idx,
  input  npc_item_t        item_in,
  output npc_item_t        item_out
);

  logic [3*COMP_W-1:0] entry_r;
  npc_item_t           a_r;
  npc_item_t           b_r;
  npc_item_t           b_nxt;
  logic [SQ_W-1:0]     sq_red_r;
  logic [SQ_W-1:0]     sq_green_r;
  logic [SQ_W-1:0]     sq_blue_r;
  logic [COMP_W-1:0]   d_red;
  logic [COMP_W-1:0]   d_green;
  logic [COMP_W-1:0]   d_blue;
  logic [DIST_W-1:0]   dist_sum;
  logic                load_hit;

  assign load_hit = item_in.valid && (item_in.op == OP_LOAD) &&
                    (CMP_W'(item_in.slot) == CMP_W'(cell_idx));

  assign d_red   = abs_diff(entry_r[3*COMP_W-1:2*COMP_W], item_in.red);
  assign d_green = abs_diff(entry_r[2*COMP_W-1:COMP_W], item_in.green);
  assign d_blue  = abs_diff(entry_r[COMP_W-1:0], item_in.blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (advance && load_hit) begin
      entry_r <= {item_in.red, item_in.green, item_in.blue};
    end
  end

  // First stage: squared component differences against the held entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (advance) begin
      a_r        <= item_in;
      sq_red_r   <= SQ_W'(SQ_W'(d_red) * SQ_W'(d_red));
      sq_green_r <= SQ_W'(SQ_W'(d_green) * SQ_W'(d_green));
      sq_blue_r  <= SQ_W'(SQ_W'(d_blue) * SQ_W'(d_blue));
    end
  end

  // Second stage: sum and keep the running best; a strict compare favours
  // the lower index on a tie.
  always_comb begin
    dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
    b_nxt    = a_r;
    if (dist_sum < a_r.best_dist) begin
      b_nxt.best_dist = dist_sum;
      b_nxt.best_idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (advance) begin
      b_r <= b_nxt;
    end
  end

  assign item_out = b_r;

endmodule

`default_nettype wire

@@ sv/npc_checker.sv @@
`default_nettype none

module npc_checker import npc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_operation,
  input logic [SLOT_W-1:0] in_entry_index,
  input logic [COMP_W-1:0] in_red,
  input logic [COMP_W-1:0] in_green,
  input logic [COMP_W-1:0] in_blue,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CIDX_W-1:0] out_colour_index,
  input logic [DIST_W-1:0] out_distance_squared
);

  // The input side only holds off while a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_squared <= DIST_MAX))
    else $error("distance beyond the largest possible RGB distance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_colour_index) && $stable(out_distance_squared)))
    else $error("stalled result changed");

endmodule

bind nearest_palette_colour npc_checker u_npc_checker (.*);

`default_nettype wire

@@ tb/sv/nearest_palette_colour_tb.sv @@
`default_nettype none

module nearest_palette_colour_tb;
  import npc_pkg::*;

  localparam int RESULT_LATENCY = 2 * PALETTE_SIZE + 1;
  localparam int STALL_LIMIT    = 5000;
  localparam int N_DIRECTED     = 22;
  localparam int N_PHASES       = 4;
  localparam int PHASE_ITEMS    = 337;
  localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 47, 0, 19};
  localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 47, 19};

  typedef struct packed {
    logic [CIDX_W-1:0] colour_index;
    logic [DIST_W-1:0] distance_squared;
  } colour_match_t;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    bit                typed;
    colour_match_t     typed_match;
  } palette_request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = OP_CLASSIFY;
  logic [SLOT_W-1:0] in_entry_index = '0;
  logic [COMP_W-1:0] in_red = '0;
  logic [COMP_W-1:0] in_green = '0;
  logic [COMP_W-1:0] in_blue = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CIDX_W-1:0] out_colour_index;
  logic [DIST_W-1:0] out_distance_squared;

  logic [3*COMP_W-1:0] palette_copy [PALETTE_SIZE];
  colour_match_t       pending_matches [$];
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  palette_request_t directed_requests [N_DIRECTED] = '{
    '{OP_CLASSIFY, 4'd0,  8'd0,   8'd0,   8'd0,   1'b1, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd15, 8'd255, 8'd255, 8'd255, 1'b1, '{4'd0,  18'd195075}},
    '{OP_LOAD,     4'd15, 8'd255, 8'd255, 8'd255, 1'b0, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd255, 8'd255, 8'd255, 1'b1, '{4'd15, 18'd0}},
    '{OP_CLASSIFY, 4'd9,  8'd0,   8'd0,   8'd0,   1'b1, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd0,  8'd255, 8'd0,   8'd0,   1'b0, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd0,   8'd0,   8'd0,   1'b1, '{4'd1,  18'd0}},
    '{OP_LOAD,     4'd1,  8'd0,   8'd255, 8'd0,   1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd2,  8'd0,   8'd0,   8'd255, 1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd3,  8'd128, 8'd128, 8'd128, 1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd4,  8'd128, 8'd128, 8'd128, 1'b0, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd4,  8'd128, 8'd128, 8'd128, 1'b1, '{4'd3,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd255, 8'd0,   8'd0,   1'b1, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd0,   8'd0,   8'd0,   1'b1, '{4'd5,  18'd0}},
    '{OP_CLASSIFY, 4'd6,  8'd130, 8'd126, 8'd129, 1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd0,  8'hAA,  8'h55,  8'hAA,  1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd7,  8'h55,  8'hAA,  8'h55,  1'b0, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd10, 8'h55,  8'hAA,  8'h55,  1'b1, '{4'd7,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd200, 8'd30,  8'd60,  1'b0, '{4'd0,  18'd0}},
    '{OP_LOAD,     4'd5,  8'd1,   8'd1,   8'd1,   1'b0, '{4'd0,  18'd0}},
    '{OP_CLASSIFY, 4'd0,  8'd0,   8'd0,   8'd0,   1'b1, '{4'd6,  18'd0}},
    '{OP_CLASSIFY, 4'd3,  8'd255, 8'd255, 8'd0,   1'b0, '{4'd0,  18'd0}}
  };

  nearest_palette_colour DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_entry_index       (in_entry_index),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_colour_index     (out_colour_index),
    .out_distance_squared (out_distance_squared)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic colour_match_t nearest_entry(input logic [COMP_W-1:0] red,
                                                  input logic [COMP_W-1:0] green,
                                                  input logic [COMP_W-1:0] blue);
    colour_match_t best;
    int dr, dg, db, sum_sq, best_dist;
    best = '0;
    best_dist = 0;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      dr = int'(palette_copy[i][23:16]) - int'(red);
      dg = int'(palette_copy[i][15:8]) - int'(green);
      db = int'(palette_copy[i][7:0]) - int'(blue);
      sum_sq = dr * dr + dg * dg + db * db;
      if (i == 0 || sum_sq < best_dist) begin
        best_dist = sum_sq;
        best.colour_index = CIDX_W'(i);
      end
    end
    best.distance_squared = DIST_W'(best_dist);
    return best;
  endfunction

  task automatic send_request(input palette_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= req.op;
    in_entry_index <= req.slot;
    in_red         <= req.red;
    in_green       <= req.green;
    in_blue        <= req.blue;
    do @(posedge clk); while (in_stall);
    if (req.op == OP_LOAD) begin
      if (int'(req.slot) < PALETTE_SIZE) begin
        palette_copy[req.slot] = {req.red, req.green, req.blue};
      end
    end else if (req.typed) begin
      pending_matches = {pending_matches, req.typed_match};
    end else begin
      pending_matches = {pending_matches, nearest_entry(req.red, req.green, req.blue)};
    end
  endtask

  // Half the pixels sit on or near a palette entry so that close races and ties
  // between entries are common; loads sometimes duplicate an entry for ties.
  task automatic send_random_requests(input int count);
    palette_request_t   req;
    logic [3*COMP_W-1:0] base;
    logic [COMP_W-1:0]  comp [3];
    int                 mode;
    int                 v;
    for (int n = 0; n < count; n++) begin
      base = palette_copy[IDX_W'($urandom_range(PALETTE_SIZE - 1))];
      mode = $urandom_range(9);
      for (int c = 0; c < 3; c++) begin
        v = int'(base[3*COMP_W-1-COMP_W*c -: COMP_W]);
        if (mode < 4) begin
          comp[c] = COMP_W'($urandom);
        end else if (mode < 6) begin
          comp[c] = COMP_W'(v);
        end else if (mode < 9) begin
          v = v + int'($urandom_range(16)) - 8;
          comp[c] = (v < 0) ? '0 : (v > 255) ? '1 : COMP_W'(v);
        end else begin
          comp[c] = $urandom_range(1) ? '1 : '0;
        end
      end
      req.op          = ($urandom_range(99) < 25) ? OP_LOAD : OP_CLASSIFY;
      req.slot        = SLOT_W'($urandom);
      req.red         = comp[0];
      req.green       = comp[1];
      req.blue        = comp[2];
      req.typed       = 1'b0;
      req.typed_match = '0;
      send_request(req);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    colour_match_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result: index %0d distance %0d",
                                  out_colour_index, out_distance_squared));
      end else begin
        want = pending_matches.pop_front();
        if (out_colour_index !== want.colour_index ||
            out_distance_squared !== want.distance_squared) begin
          report_mismatch($sformatf(
            "result mismatch: expected index %0d distance %0d, got index %0d distance %0d",
            want.colour_index, want.distance_squared,
            out_colour_index, out_distance_squared));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < PALETTE_SIZE; i++) palette_copy[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < N_DIRECTED; k++) send_request(directed_requests[k]);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      send_random_requests(PHASE_ITEMS);
    end
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ nearest_palette_colour.f @@
sv/npc_pkg.sv
sv/npc_cell.sv
sv/nearest_palette_colour.sv
sv/npc_checker.sv
tb/sv/nearest_palette_colour_tb.sv
